>>> hdl/opd_pkg.sv
// Package for the DSP opcode priority decoder.
// Holds the pattern table, field widths, special row numbers and shared types.
// No dependencies.
package opd_pkg;

  localparam int WORD_W = 24;
  localparam int ADDR_W = 16;
  localparam int ROW_W  = 7;
  localparam int EA_W   = 6;

  localparam int TABLE_SIZE   = 81;
  localparam int PATTERN_ROWS = 81;
  localparam int ACTIVE_ROWS  = (PATTERN_ROWS < TABLE_SIZE) ? PATTERN_ROWS : TABLE_SIZE;

  localparam logic [ROW_W-1:0] ROW_SHORT_JUMP  = 7'd3;
  localparam logic [ROW_W-1:0] ROW_PERIPH_MOVE = 7'd40;

  localparam logic [EA_W-1:0]   EA_ABSOLUTE  = 6'h30;
  localparam logic [EA_W-1:0]   EA_IMMEDIATE = 6'h34;
  localparam logic [ADDR_W-1:0] IO_BASE      = 16'hFFC0;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [ROW_W-1:0]  row_t;

  typedef struct packed {
    logic hit;
    row_t row;
  } match_t;

  typedef struct packed {
    logic       matched;
    row_t       row_index;
    addr_t      instruction_address;
    addr_t      next_address;
    logic       uses_extension;
    addr_t      io_address;
    logic       memory_space_y;
    logic       peripheral_space_y;
    logic [2:0] ea_mode;
    logic [2:0] ea_register;
    logic       to_peripheral;
  } result_t;

  localparam word_t PAT_MASK [TABLE_SIZE] = '{
    24'hFF0000, 24'hFF0000, 24'hFFF000, 24'hFFF000, 24'hFFC0A0, 24'hFFC0FF, 24'hFFC0F0,
    24'hFFC0FF, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0,
    24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0E0,
    24'hFFC0E0, 24'hFFC0E0, 24'hFFC0E0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0,
    24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0, 24'hFFC0A0,
    24'hFFC0A0, 24'hFFC0E0, 24'hFFC0E0, 24'hFFC0E0, 24'hFFC0E0, 24'hFE4080, 24'hFE40C0,
    24'hFE40C0, 24'hFF40C0, 24'hFF40C0, 24'hFF00F0, 24'hFFC0FF, 24'hFFC0BF, 24'hFFC0BF,
    24'hFF00F0, 24'hFFC0FF, 24'hFFC0B0, 24'hFFC0B0, 24'hFF00E0, 24'hFF40A0, 24'hFF40A0,
    24'hFF40E0, 24'hFFE0F0, 24'hFF0880, 24'hFF0F87, 24'hFFF8F7, 24'hFFFFC7, 24'hFFE0C3,
    24'hFFE0C3, 24'hFFE0C3, 24'hFFE0C3, 24'hFFFFF0, 24'hFFFFFF, 24'hFF00FC, 24'hFF00FC,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFE, 24'hFFFFFE,
    24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF
  };

  localparam word_t PAT_CONST [TABLE_SIZE] = '{
    24'h0F0000, 24'h0E0000, 24'h0D0000, 24'h0C0000, 24'h0BC0A0, 24'h0BC080, 24'h0AC0A0,
    24'h0AC080, 24'h0B80A0, 24'h0B8080, 24'h0A80A0, 24'h0A8080, 24'h0B40A0, 24'h0B4080,
    24'h0A40A0, 24'h0A4080, 24'h0B00A0, 24'h0B0080, 24'h0A00A0, 24'h0A0080, 24'h0BC020,
    24'h0BC000, 24'h0AC020, 24'h0AC000, 24'h0B8020, 24'h0B8000, 24'h0A8020, 24'h0A8000,
    24'h0B4020, 24'h0B4000, 24'h0A4020, 24'h0A4000, 24'h0B0020, 24'h0B0000, 24'h0A0020,
    24'h0A0000, 24'h0BC060, 24'h0BC040, 24'h0AC060, 24'h0AC040, 24'h084080, 24'h084040,
    24'h084000, 24'h074080, 24'h070000, 24'h0600A0, 24'h06C020, 24'h064020, 24'h060020,
    24'h060080, 24'h06C000, 24'h064000, 24'h060000, 24'h0500A0, 24'h054020, 24'h050020,
    24'h0440A0, 24'h044010, 24'h030000, 24'h020000, 24'h01D815, 24'h018040, 24'h0100C2,
    24'h0100C3, 24'h0100C0, 24'h0100C1, 24'h000300, 24'h000200, 24'h0000F8, 24'h0000B8,
    24'h00008C, 24'h000087, 24'h000086, 24'h000084, 24'h00000C, 24'h00000A, 24'h000008,
    24'h000006, 24'h000005, 24'h000004, 24'h000000
  };

endpackage

>>> hdl/opd_if.sv
// Channel interfaces for the DSP opcode priority decoder.
// Depends on opd_pkg for field types.
interface opd_in_if;
  logic          valid;
  logic          ready;
  opd_pkg::word_t instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink (input valid, input instruction_word, output ready);
endinterface

interface opd_out_if;
  logic           valid;
  logic           ready;
  logic           matched;
  opd_pkg::row_t  row_index;
  opd_pkg::addr_t instruction_address;
  opd_pkg::addr_t next_address;
  logic           uses_extension;
  opd_pkg::addr_t io_address;
  logic           memory_space_y;
  logic           peripheral_space_y;
  logic [2:0]     ea_mode;
  logic [2:0]     ea_register;
  logic           to_peripheral;

  modport source (
    output valid, input ready, output matched, output row_index,
    output instruction_address, output next_address, output uses_extension,
    output io_address, output memory_space_y, output peripheral_space_y,
    output ea_mode, output ea_register, output to_peripheral
  );
  modport sink (
    input valid, output ready, input matched, input row_index,
    input instruction_address, input next_address, input uses_extension,
    input io_address, input memory_space_y, input peripheral_space_y,
    input ea_mode, input ea_register, input to_peripheral
  );
endinterface

>>> hdl/dsp_opcode_priority_decoder.sv
// Top level of the DSP opcode priority decoder.
// Depends on opd_pkg, opd_if.sv (channel interfaces) and opd_match.
//
// Decodes one 24-bit instruction word per clock while out_ch keeps up.
// A word accepted on in_ch is held in an input register; from there it is
// matched against the pattern table and the full result, including the
// program address it was fetched from and the address of the following
// instruction, is written to the output register once that register is
// free or being read, so the throughput is one transaction per cycle
// unless out_ch stalls. The program address counter advances as each word
// is decoded, which is what lets the following word be decoded without
// waiting on it. Writing cfg_wr_data with cfg_wr_en high loads the counter
// with a new start address; do this only while no transaction is in flight.
module dsp_opcode_priority_decoder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  opd_pkg::addr_t  cfg_wr_data,
  opd_in_if.sink          in_ch,
  opd_out_if.source       out_ch
);

  logic             s1_valid_r;
  opd_pkg::word_t   s1_word_r;
  logic             out_valid_r;
  opd_pkg::result_t out_r;
  opd_pkg::result_t out_nxt;
  opd_pkg::addr_t   prog_addr_r;
  opd_pkg::addr_t   prog_addr_nxt;
  opd_pkg::match_t  match;
  logic [opd_pkg::EA_W-1:0] ea;
  logic             out_load;
  logic             s1_advance;

  assign out_load   = !out_valid_r || out_ch.ready;
  assign s1_advance = s1_valid_r && out_load;
  assign in_ch.ready = !s1_valid_r || out_load;

  opd_match u_match (
    .word   (s1_word_r),
    .result (match)
  );

  assign ea = s1_word_r[13:8];

  always_comb begin
    out_nxt                     = '0;
    out_nxt.matched             = match.hit;
    out_nxt.row_index           = match.row;
    out_nxt.instruction_address = prog_addr_r;
    out_nxt.next_address        = prog_addr_r + opd_pkg::ADDR_W'(1);
    if (match.hit && match.row == opd_pkg::ROW_SHORT_JUMP) begin
      out_nxt.next_address = {4'b0, s1_word_r[11:0]};
    end else if (match.hit && match.row == opd_pkg::ROW_PERIPH_MOVE) begin
      out_nxt.io_address         = opd_pkg::IO_BASE | {10'b0, s1_word_r[5:0]};
      out_nxt.memory_space_y     = s1_word_r[6];
      out_nxt.peripheral_space_y = s1_word_r[16];
      out_nxt.to_peripheral      = s1_word_r[15];
      out_nxt.ea_mode            = ea[5:3];
      out_nxt.ea_register        = ea[2:0];
      // Absolute and immediate addressing carry an extension word to skip.
      if (ea == opd_pkg::EA_ABSOLUTE || ea == opd_pkg::EA_IMMEDIATE) begin
        out_nxt.uses_extension = 1'b1;
        out_nxt.next_address   = prog_addr_r + opd_pkg::ADDR_W'(2);
      end
    end
  end

  always_comb begin
    prog_addr_nxt = prog_addr_r;
    if (cfg_wr_en) begin
      prog_addr_nxt = cfg_wr_data;
    end else if (s1_advance) begin
      prog_addr_nxt = out_nxt.next_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      prog_addr_r <= '0;
    end else begin
      prog_addr_r <= prog_addr_nxt;
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_word_r <= in_ch.instruction_word;
    end
    if (s1_advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.matched             = out_r.matched;
  assign out_ch.row_index           = out_r.row_index;
  assign out_ch.instruction_address = out_r.instruction_address;
  assign out_ch.next_address        = out_r.next_address;
  assign out_ch.uses_extension      = out_r.uses_extension;
  assign out_ch.io_address          = out_r.io_address;
  assign out_ch.memory_space_y      = out_r.memory_space_y;
  assign out_ch.peripheral_space_y  = out_r.peripheral_space_y;
  assign out_ch.ea_mode             = out_r.ea_mode;
  assign out_ch.ea_register         = out_r.ea_register;
  assign out_ch.to_peripheral       = out_r.to_peripheral;

endmodule

>>> hdl/opd_match.sv
// Pattern matcher: compares one word against every active table row in
// parallel and picks the lowest matching row. Depends on opd_pkg.
module opd_match (
  input  opd_pkg::word_t  word,
  output opd_pkg::match_t result
);

  logic [opd_pkg::ACTIVE_ROWS-1:0] hit_vec;

  always_comb begin
    for (int i = 0; i < opd_pkg::ACTIVE_ROWS; i++) begin
      hit_vec[i] = ((word & opd_pkg::PAT_MASK[i]) == opd_pkg::PAT_CONST[i]);
    end
  end

  // Scanning from the top down leaves the lowest hitting row in place.
  always_comb begin
    result.hit = 1'b0;
    result.row = '0;
    for (int i = opd_pkg::ACTIVE_ROWS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        result.hit = 1'b1;
        result.row = opd_pkg::ROW_W'(i);
      end
    end
  end

endmodule
